>>> src/dcm_pkg.sv
// ----------------------------------------------------------------------------
// dcm_pkg
// Shared types and constants for the decimating channel mean core.
// ----------------------------------------------------------------------------
package dcm_pkg;

  localparam int WORD_W     = 16;
  localparam int CNT_W      = 6;
  localparam int SPAD_W     = 5;
  localparam int DECIM_W    = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CNT_W-1:0]   CHANNEL_COUNT_RST   = 6'd8;
  localparam logic [SPAD_W-1:0]  SPAD_PAIR_COUNT_RST = 5'd0;
  localparam logic [DECIM_W-1:0] DECIM_LOG2_RST      = 5'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT   = 2'd0,
    CFG_SPAD_PAIR_COUNT = 2'd1,
    CFG_DECIM_LOG2      = 2'd2
  } cfg_index_t;

  // What the framer says about the word at the head of the stream.
  typedef struct packed {
    logic is_chan;  // word belongs to an averaged channel
    logic emit;     // word is part of a window's last sample
    logic last;     // final word of the sample
  } frame_flags_t;

endpackage

>>> src/dcm_framer.sv
// ----------------------------------------------------------------------------
// dcm_framer
// Tracks word position within a sample and sample index within a window.
// ----------------------------------------------------------------------------
module dcm_framer #(
  parameter int POS_W = 7,
  parameter int SIW   = 16,
  parameter int SH_W  = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  restart,
  input  logic                  advance,
  input  logic [POS_W-1:0]      eff_ch,
  input  logic [POS_W-1:0]      width,
  input  logic [SH_W-1:0]       eff_sh,
  output logic [POS_W-1:0]      pos,
  output dcm_pkg::frame_flags_t flags
);
  import dcm_pkg::*;

  logic [POS_W-1:0] word_position;
  logic [SIW-1:0]   sample_index;
  logic [SIW:0]     one_sh;
  logic [SIW-1:0]   last_idx;
  logic             last_sample;
  logic [POS_W-1:0] pos_inc;
  logic             wrap;

  always_comb begin
    pos           = (word_position >= width) ? '0 : word_position;
    one_sh        = (SIW+1)'(1) << eff_sh;
    last_idx      = SIW'(one_sh - 1'b1);
    last_sample   = sample_index >= last_idx;
    flags.is_chan = pos < eff_ch;
    flags.emit    = last_sample;
    flags.last    = pos == (width - 1'b1);
    pos_inc       = pos + 1'b1;
    wrap          = pos_inc >= width;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      word_position <= '0;
      sample_index  <= '0;
    end else if (advance) begin
      word_position <= wrap ? '0 : pos_inc;
      // step the window only once the whole sample has gone by
      if (wrap) begin
        sample_index <= last_sample ? '0 : sample_index + 1'b1;
      end
    end
  end

endmodule

>>> src/decimating_channel_mean_core.sv
// ----------------------------------------------------------------------------
// decimating_channel_mean_core
// Boxcar decimating average over an interleaved stream of 16-bit words.
// ----------------------------------------------------------------------------
// Takes one stream word per clock while the output does not stall it: the
// only loop is the read-add-write of a channel's running sum, which a two-stage
// pipeline (sum memory read, then add and write back with forwarding) closes
// for back-to-back words. A result passes the s1 stage register and then waits
// in an output register, so input keeps flowing while it is held unless the
// next word also has a result to give. Only words of a
// window's last sample produce results; the output
// frame has the layout of one sample and its final word carries frame_last.
// Sums start at zero after reset and after any register write through valid
// bits, so there is no clearing pass. Write registers only while idle.
// ----------------------------------------------------------------------------
module decimating_channel_mean_core #(
  parameter int MAX_CHANNELS   = 32,
  parameter int MAX_SPAD_PAIRS = 16,
  parameter int MAX_DECIM_LOG2 = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dcm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dcm_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  sample_valid,
  output logic                                  sample_ready,
  input  logic signed [dcm_pkg::WORD_W-1:0]     sample_word,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic signed [dcm_pkg::WORD_W-1:0]     out_word,
  output logic                                  frame_last
);
  import dcm_pkg::*;

  localparam int MAXW  = MAX_CHANNELS + 2 * MAX_SPAD_PAIRS;
  localparam int POS_W = $clog2(MAXW + 1);
  localparam int CH_AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int SIW   = MAX_DECIM_LOG2;
  localparam int SH_W  = $clog2(MAX_DECIM_LOG2 + 1);
  localparam int SUM_W = WORD_W + MAX_DECIM_LOG2;

  // configuration
  logic [CNT_W-1:0]   channel_count;
  logic [SPAD_W-1:0]  spad_pair_count;
  logic [DECIM_W-1:0] decim_log2;
  logic               restart;
  logic [POS_W-1:0]   eff_ch;
  logic [POS_W-1:0]   eff_sp;
  logic [POS_W-1:0]   width;
  logic [SH_W-1:0]    eff_sh;

  // framing
  logic               in_xfer;
  logic [POS_W-1:0]   in_pos;
  logic [CH_AW-1:0]   in_idx;
  frame_flags_t       in_flags;

  // sum stage
  logic                     s1_valid;
  logic                     s1_adv;
  logic signed [WORD_W-1:0] s1_word;
  logic [CH_AW-1:0]         s1_idx;
  frame_flags_t             s1_flags;
  logic [SUM_W-1:0]         rd_data;
  logic                     rd_vld;
  logic                     fwd_hit;
  logic [SUM_W-1:0]         fwd_data;
  logic [SUM_W-1:0]         s1_base;
  logic signed [SUM_W-1:0]  s1_sum;
  logic signed [SUM_W-1:0]  s1_shifted;
  logic [SUM_W-1:0]         s1_wdata;
  logic                     out_free;

  logic [SUM_W-1:0]        sums [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] sum_vld;

  assign cfg_ready = 1'b1;

  always_comb begin
    restart = 1'b0;
    if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_CHANNEL_COUNT:   restart = 1'b1;
        CFG_SPAD_PAIR_COUNT: restart = 1'b1;
        CFG_DECIM_LOG2:      restart = 1'b1;
        default:             restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count   <= CHANNEL_COUNT_RST;
      spad_pair_count <= SPAD_PAIR_COUNT_RST;
      decim_log2      <= DECIM_LOG2_RST;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_CHANNEL_COUNT:   channel_count   <= cfg_data[CNT_W-1:0];
        CFG_SPAD_PAIR_COUNT: spad_pair_count <= cfg_data[SPAD_W-1:0];
        CFG_DECIM_LOG2:      decim_log2      <= cfg_data[DECIM_W-1:0];
        default:             ;
      endcase
    end
  end

  // clamp registers to the built ranges
  always_comb begin
    if (channel_count == '0) begin
      eff_ch = POS_W'(1);
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      eff_ch = POS_W'(MAX_CHANNELS);
    end else begin
      eff_ch = POS_W'(channel_count);
    end
    if (32'(spad_pair_count) > MAX_SPAD_PAIRS) begin
      eff_sp = POS_W'(MAX_SPAD_PAIRS);
    end else begin
      eff_sp = POS_W'(spad_pair_count);
    end
    if (32'(decim_log2) > MAX_DECIM_LOG2) begin
      eff_sh = SH_W'(MAX_DECIM_LOG2);
    end else begin
      eff_sh = SH_W'(decim_log2);
    end
    width = eff_ch + (eff_sp << 1);
  end

  dcm_framer #(
    .POS_W (POS_W),
    .SIW   (SIW),
    .SH_W  (SH_W)
  ) u_framer (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .advance (in_xfer),
    .eff_ch  (eff_ch),
    .width   (width),
    .eff_sh  (eff_sh),
    .pos     (in_pos),
    .flags   (in_flags)
  );

  assign in_idx       = in_pos[CH_AW-1:0];
  assign out_free     = !result_valid || result_ready;
  assign s1_adv       = s1_valid && (!s1_flags.emit || out_free);
  assign sample_ready = !s1_valid || s1_adv;
  assign in_xfer      = sample_valid && sample_ready;

  always_comb begin
    s1_base    = fwd_hit ? fwd_data : (rd_vld ? rd_data : '0);
    s1_sum     = s1_base + SUM_W'(s1_word);
    s1_shifted = s1_sum >>> eff_sh;
    s1_wdata   = s1_flags.emit ? '0 : s1_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid <= 1'b1;
        // bypass a write to the same channel landing at this edge
        fwd_hit  <= s1_adv && s1_flags.is_chan && in_flags.is_chan && (s1_idx == in_idx);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_word  <= sample_word;
      s1_idx   <= in_idx;
      s1_flags <= in_flags;
      fwd_data <= s1_wdata;
      rd_vld   <= sum_vld[in_idx];
    end
  end

  // running sum memory
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_data <= sums[in_idx];
    end
    if (s1_adv && s1_flags.is_chan) begin
      sums[s1_idx] <= s1_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      sum_vld <= '0;
    end else if (s1_adv && s1_flags.is_chan) begin
      sum_vld[s1_idx] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv && s1_flags.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_flags.emit) begin
      out_word   <= s1_flags.is_chan ? s1_shifted[WORD_W-1:0] : s1_word;
      frame_last <= s1_flags.last;
    end
  end

endmodule

>>> src/dcm_checker.sv
// ----------------------------------------------------------------------------
// dcm_checker
// Port-level checks for the decimating channel mean core.
// ----------------------------------------------------------------------------
module dcm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic                              sample_valid,
  input logic                              sample_ready,
  input logic                              result_valid,
  input logic                              result_ready,
  input logic signed [dcm_pkg::WORD_W-1:0] out_word,
  input logic                              frame_last
);
  import dcm_pkg::*;

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(out_word) && $stable(frame_last))
    else $error("result changed while stalled");

  // nothing is left in flight by reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && sample_ready)
    else $error("pipeline not empty after reset");

  // a new result needs an earlier sample transfer through the s1 stage register
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(sample_valid && sample_ready, 2))
    else $error("result appeared without a sample transfer");

  // configuration is never back-pressured
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind decimating_channel_mean_core dcm_checker u_dcm_checker (.*);
